// ===== design/assert_macros.svh =====
// assertion macros included by kruskal_mst_weight
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// property holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// antecedent implies consequent on the next edge
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

// ===== design/kmst_pkg.sv =====
// package for the kruskal spanning forest block
// constants only; no dependencies
package kmst_pkg;
	localparam int MaxVertices = 128;
	localparam int MaxEdges    = 1024;
	localparam int WeightBits  = 14;
	localparam int VtxW        = 8;
	localparam int SumW        = 21;
	localparam logic [SumW-1:0] SumMax = '1;
endpackage

// ===== design/kmst_if.sv =====
// valid/ready channel interfaces for the kruskal block
// depends on kmst_pkg
interface kmst_edge_if #(parameter int WB = kmst_pkg::WeightBits);
	logic valid;
	logic ready;
	logic [kmst_pkg::VtxW-1:0] src_vertex;
	logic [kmst_pkg::VtxW-1:0] dst_vertex;
	logic [WB-1:0] edge_weight;
	logic last_edge;
	modport source(output valid, src_vertex, dst_vertex, edge_weight, last_edge, input ready);
	modport sink(input valid, src_vertex, dst_vertex, edge_weight, last_edge, output ready);
endinterface

interface kmst_res_if;
	logic valid;
	logic ready;
	logic [kmst_pkg::SumW-1:0] tree_weight;
	logic overflow;
	modport source(output valid, tree_weight, overflow, input ready);
	modport sink(input valid, tree_weight, overflow, output ready);
endinterface

interface kmst_cfg_if;
	logic valid;
	logic ready;
	logic [kmst_pkg::VtxW-1:0] data;
	modport source(output valid, data, input ready);
	modport sink(input valid, data, output ready);
endinterface

// ===== design/kruskal_mst_weight.sv =====
// kruskal spanning forest weight: edges load one per cycle while input is ready
// after a last_edge beat: sweep of parent/size entries 0 to MAX_VERTICES, then per edge a serial scan
// for the next edge in (weight, index) order and a union-find step that walks both root
// paths, compresses them and links the two roots by size
// input is not ready from the last_edge beat until the result beat is taken
// arst_n clears control state; memories are not cleared
`include "assert_macros.svh"
module kruskal_mst_weight #(
	parameter int MAX_VERTICES = kmst_pkg::MaxVertices,
	parameter int MAX_EDGES    = kmst_pkg::MaxEdges,
	parameter int WEIGHT_BITS  = kmst_pkg::WeightBits
) (
	input logic clk,
	input logic arst_n,
	kmst_cfg_if.sink cfg,
	kmst_edge_if.sink edge_in,
	kmst_res_if.source res
);
	localparam int EA = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int EC = $clog2(MAX_EDGES + 1);
	localparam int VA = $clog2(MAX_VERTICES + 1);
	localparam int VW = kmst_pkg::VtxW;
	localparam int SW = kmst_pkg::SumW;
	localparam int ZW = VA + 1;

	typedef enum logic [4:0] {
		S_LOAD, S_INIT, S_SCAN_RD, S_SCAN, S_SCAN_END, S_PICK_RD, S_PICK,
		S_FA_RD, S_FA, S_FB_RD, S_FB, S_CA_RD, S_CA, S_CB_RD, S_CB,
		S_SZ_RD, S_SZ, S_LINK, S_OUT
	} state_t;

	state_t state_q;
	logic [VW-1:0] vcount_q;
	logic [EC-1:0] ecount_q;
	logic ovf_q;
	logic [SW-1:0] sum_q;

	// edge memories
	logic [VW-1:0] esrc_mem [MAX_EDGES];
	logic [VW-1:0] edst_mem [MAX_EDGES];
	logic [WEIGHT_BITS-1:0] ew_mem [MAX_EDGES];
	logic [EA-1:0] e_rd;
	logic [VW-1:0] esrc_rd, edst_rd;
	logic [WEIGHT_BITS-1:0] ew_rd;

	// union-find memories
	logic [VA-1:0] par_mem [MAX_VERTICES + 1];
	logic [ZW-1:0] size_mem [MAX_VERTICES + 1];
	logic [VA-1:0] v_rd, par_rd;
	logic [ZW-1:0] size_rd;
	logic par_we, size_we;
	logic [VA-1:0] par_wa, par_wd, size_wa;
	logic [ZW-1:0] size_wd;

	logic [EC-1:0] idx_q;
	logic found_q;
	logic [EA-1:0] best_q;
	logic [WEIGHT_BITS-1:0] bestw_q;
	logic [EA-1:0] lasti_q;
	logic [WEIGHT_BITS-1:0] lastw_q;
	logic [EA-1:0] scan_j;
	logic [VA-1:0] a_q, b_q, ra_q, rb_q, cur_q;
	logic [ZW-1:0] sza_q;
	logic [EC-1:0] done_q;
	logic [VA-1:0] n_eff;

	logic in_beat, cfg_beat, out_beat;
	assign in_beat  = edge_in.valid && edge_in.ready;
	assign cfg_beat = cfg.valid && cfg.ready;
	assign out_beat = res.valid && res.ready;
	assign edge_in.ready = (state_q == S_LOAD);
	assign cfg.ready = 1'b1;
	assign res.valid = (state_q == S_OUT);
	assign res.tree_weight = sum_q;
	assign res.overflow = ovf_q;

	// index of the edge whose read data is on ew_rd during a scan
	assign scan_j = idx_q[EA-1:0] - EA'(1);

	// effective vertex count
	always_comb begin
		if (vcount_q == '0) n_eff = VA'(1);
		else if (32'(vcount_q) > MAX_VERTICES) n_eff = VA'(MAX_VERTICES);
		else n_eff = VA'(vcount_q);
	end

	// edge memory write and registered read
	always_ff @(posedge clk) begin
		if (in_beat && ecount_q < EC'(MAX_EDGES)) begin
			esrc_mem[ecount_q[EA-1:0]] <= edge_in.src_vertex;
			edst_mem[ecount_q[EA-1:0]] <= edge_in.dst_vertex;
			ew_mem[ecount_q[EA-1:0]] <= edge_in.edge_weight;
		end
		esrc_rd <= esrc_mem[e_rd];
		edst_rd <= edst_mem[e_rd];
		ew_rd <= ew_mem[e_rd];
	end

	// union-find memory ports
	always_ff @(posedge clk) begin
		if (par_we) par_mem[par_wa] <= par_wd;
		if (size_we) size_mem[size_wa] <= size_wd;
		par_rd <= par_mem[v_rd];
		size_rd <= size_mem[v_rd];
	end

	// read address and write selection
	always_comb begin
		e_rd = (state_q == S_PICK_RD) ? best_q : idx_q[EA-1:0];
		v_rd = cur_q;
		par_we = 1'b0; size_we = 1'b0;
		par_wa = cur_q; par_wd = cur_q;
		size_wa = cur_q; size_wd = ZW'(1);
		case (state_q)
			S_INIT: begin
				par_we = 1'b1; size_we = 1'b1;
			end
			S_CA, S_CB: begin
				par_we = (par_rd != ((state_q == S_CA) ? ra_q : rb_q));
				par_wd = (state_q == S_CA) ? ra_q : rb_q;
			end
			S_SZ_RD: v_rd = ra_q;
			// sza_q holds the size of ra, size_rd the size of rb
			S_LINK: begin
				par_we = 1'b1; size_we = 1'b1;
				if (sza_q < size_rd) begin
					par_wa = ra_q; par_wd = rb_q; size_wa = rb_q;
				end else begin
					par_wa = rb_q; par_wd = ra_q; size_wa = ra_q;
				end
				size_wd = sza_q + size_rd;
			end
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			vcount_q <= VW'(1);
			ecount_q <= '0;
			ovf_q <= 1'b0;
			sum_q <= '0;
			idx_q <= '0;
			found_q <= 1'b0;
			best_q <= '0;
			bestw_q <= '0;
			lasti_q <= '0;
			lastw_q <= '0;
			a_q <= '0; b_q <= '0; ra_q <= '0; rb_q <= '0; cur_q <= '0;
			sza_q <= '0;
			done_q <= '0;
		end else begin
			if (cfg_beat) vcount_q <= cfg.data;
			case (state_q)
				S_LOAD: if (in_beat) begin
					if (ecount_q < EC'(MAX_EDGES)) ecount_q <= ecount_q + EC'(1);
					else ovf_q <= 1'b1;
					if (edge_in.last_edge) begin
						state_q <= S_INIT;
						cur_q <= '0;
						sum_q <= '0;
						done_q <= '0;
					end
				end
				S_INIT: begin
					cur_q <= cur_q + VA'(1);
					if (cur_q == VA'(MAX_VERTICES)) state_q <= S_SCAN_RD;
				end
				S_SCAN_RD: begin
					if (done_q == ecount_q) state_q <= S_OUT;
					else begin
						idx_q <= '0; found_q <= 1'b0; state_q <= S_SCAN;
					end
				end
				// one edge compared per cycle; read data is registered and belongs to the previous address
				// candidates come after the last pick in (weight, index) order
				S_SCAN: begin
					idx_q <= idx_q + EC'(1);
					if (idx_q != '0) begin
						if ((done_q == '0 || ew_rd > lastw_q ||
							(ew_rd == lastw_q && scan_j > lasti_q)) &&
							(!found_q || ew_rd < bestw_q)) begin
							found_q <= 1'b1;
							best_q <= scan_j;
							bestw_q <= ew_rd;
						end
					end
					if (idx_q == ecount_q) state_q <= S_SCAN_END;
				end
				S_SCAN_END: state_q <= S_PICK_RD;
				S_PICK_RD: begin
					lasti_q <= best_q;
					lastw_q <= bestw_q;
					done_q <= done_q + EC'(1);
					state_q <= S_PICK;
				end
				S_PICK: begin
					a_q <= VA'(esrc_rd); b_q <= VA'(edst_rd);
					if (esrc_rd == '0 || edst_rd == '0 || 9'(esrc_rd) > 9'(n_eff) ||
						9'(edst_rd) > 9'(n_eff)) state_q <= S_SCAN_RD;
					else begin
						cur_q <= VA'(esrc_rd); state_q <= S_FA_RD;
					end
				end
				// root walks
				S_FA_RD: state_q <= S_FA;
				S_FA: begin
					if (par_rd == cur_q) begin
						ra_q <= cur_q; cur_q <= b_q; state_q <= S_FB_RD;
					end else begin
						cur_q <= par_rd; state_q <= S_FA_RD;
					end
				end
				S_FB_RD: state_q <= S_FB;
				S_FB: begin
					if (par_rd == cur_q) begin
						rb_q <= cur_q; cur_q <= a_q; state_q <= S_CA_RD;
					end else begin
						cur_q <= par_rd; state_q <= S_FB_RD;
					end
				end
				// path compression
				S_CA_RD: state_q <= S_CA;
				S_CA: begin
					if (cur_q == ra_q) begin
						cur_q <= b_q; state_q <= S_CB_RD;
					end else begin
						cur_q <= par_rd; state_q <= S_CA_RD;
					end
				end
				S_CB_RD: state_q <= S_CB;
				S_CB: begin
					if (cur_q == rb_q) begin
						if (ra_q == rb_q) state_q <= S_SCAN_RD;
						else state_q <= S_SZ_RD;
					end else begin
						cur_q <= par_rd; state_q <= S_CB_RD;
					end
				end
				// size of ra, then size of rb through cur_q
				S_SZ_RD: state_q <= S_SZ;
				S_SZ: begin
					sza_q <= size_rd; state_q <= S_LINK;
				end
				S_LINK: begin
					if ({1'b0, sum_q} + (SW + 1)'(bestw_q) > (SW + 1)'(kmst_pkg::SumMax))
						sum_q <= kmst_pkg::SumMax;
					else sum_q <= sum_q + SW'(bestw_q);
					state_q <= S_SCAN_RD;
				end
				S_OUT: if (out_beat) begin
					ecount_q <= '0; ovf_q <= 1'b0; state_q <= S_LOAD;
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	`ASSERT_ALWAYS(a_no_in_busy, clk, arst_n, !(in_beat && state_q != S_LOAD), "beat while busy")
	`ASSERT_ALWAYS(a_count_rng, clk, arst_n, ecount_q <= EC'(MAX_EDGES), "edge count range")
	`ASSERT_NEXT(a_out_hold, clk, arst_n, res.valid && !res.ready, res.valid && $stable(sum_q), "result dropped")
endmodule
